FILE: rtl/mtfbc_pkg.sv
`timescale 1ns / 1ps

package mtfbc_pkg;

    localparam int SYM_W = 8;
    localparam int ALPHABET_SIZE = 256;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    typedef struct packed {
        logic             dir;
        logic [SYM_W-1:0] key;
    } t_cell_ctl;

    typedef struct packed {
        logic             tok;
        logic [SYM_W-1:0] carry;
    } t_wave;

endpackage

FILE: rtl/mtfbc_cell.sv
`timescale 1ns / 1ps

module mtfbc_cell #(
    parameter int IDX = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mtfbc_pkg::t_cell_ctl       i_ctl,
    input  mtfbc_pkg::t_wave           i_wave,
    input  logic                       i_load,
    input  logic [mtfbc_pkg::SYM_W-1:0] i_load_val,
    output mtfbc_pkg::t_wave           o_wave,
    output logic                       o_hit,
    output logic [mtfbc_pkg::SYM_W-1:0] o_hit_val
);

    logic [mtfbc_pkg::SYM_W-1:0] r_val;
    logic [mtfbc_pkg::SYM_W-1:0] n_val;
    mtfbc_pkg::t_wave            r_wave;
    mtfbc_pkg::t_wave            n_wave;
    logic                        w_match;

    always_comb begin
        if (i_ctl.dir) begin
            w_match = (i_ctl.key == mtfbc_pkg::SYM_W'(IDX));
        end else begin
            w_match = (i_ctl.key == r_val);
        end
        o_hit     = i_wave.tok && w_match;
        o_hit_val = o_hit ? r_val : '0;
        n_val     = r_val;
        if (i_load) begin
            n_val = i_load_val;
        end else if (i_wave.tok) begin
            n_val = i_wave.carry;
        end
        n_wave.tok   = i_wave.tok && !w_match;
        n_wave.carry = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val      <= mtfbc_pkg::SYM_W'(IDX);
            r_wave.tok <= 1'b0;
        end else begin
            r_val      <= n_val;
            r_wave.tok <= n_wave.tok;
        end
        r_wave.carry <= n_wave.carry;
    end

    assign o_wave = r_wave;

endmodule

FILE: rtl/move_to_front_byte_codec.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_ready          i_symbol_in
// result    out        o_valid / i_ready          o_symbol_out
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (direction)
//
// One item at a time: a wave walks the cell chain one cell per cycle and
// stops at the list position hit (the saturated position when decoding);
// an out-of-alphabet encode skips the walk. A new item is taken once the
// last result is registered. Reset restores the list to ascending order
// at once. A stalled result holds the wave's finish until it is taken.

module move_to_front_byte_codec #(
    parameter int ALPHABET_SIZE = mtfbc_pkg::ALPHABET_SIZE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mtfbc_pkg::SYM_W-1:0] i_symbol_in,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mtfbc_pkg::SYM_W-1:0] o_symbol_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);

    localparam int SW = mtfbc_pkg::SYM_W;
    localparam logic [SW:0] NSZ  = (SW + 1)'(ALPHABET_SIZE);
    localparam logic [SW:0] NLST = (SW + 1)'(ALPHABET_SIZE - 1);

    mtfbc_pkg::t_state    r_state;
    mtfbc_pkg::t_state    n_state;
    logic                 r_dir;
    logic [SW-1:0]        r_key;
    logic [SW-1:0]        n_key;
    logic                 r_launch;
    logic [SW-1:0]        r_idx;
    logic [SW-1:0]        r_found;
    logic [SW-1:0]        r_rank;
    logic                 r_wr;
    logic                 r_out_valid;
    logic [SW-1:0]        r_out;
    logic                 w_accept;
    logic                 w_finish;
    logic                 w_hit_any;
    logic [SW-1:0]        w_hit_val;
    mtfbc_pkg::t_cell_ctl w_ctl;
    mtfbc_pkg::t_wave     w_wave [ALPHABET_SIZE+1];
    logic                 w_hit [ALPHABET_SIZE];
    logic [SW-1:0]        w_hval [ALPHABET_SIZE];

    assign o_cfg_ready  = 1'b1;
    assign o_ready      = (r_state == mtfbc_pkg::S_IDLE);
    assign w_accept     = i_valid && o_ready;
    assign w_finish     = (r_state == mtfbc_pkg::S_FIN) && (!r_out_valid || i_ready);
    assign o_valid      = r_out_valid;
    assign o_symbol_out = r_out;

    assign w_ctl.dir       = r_dir;
    assign w_ctl.key       = r_key;
    assign w_wave[0].tok   = r_launch;
    assign w_wave[0].carry = r_key;

    genvar g;
    generate
        for (g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
            mtfbc_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_wave     (w_wave[g]),
                .i_load     ((g == 0) && w_finish && r_wr),
                .i_load_val (r_found),
                .o_wave     (w_wave[g+1]),
                .o_hit      (w_hit[g]),
                .o_hit_val  (w_hval[g])
            );
        end
    endgenerate

    always_comb begin
        w_hit_any = 1'b0;
        w_hit_val = '0;
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
            w_hit_any = w_hit_any | w_hit[k];
            w_hit_val = w_hit_val | w_hval[k];
        end
    end

    always_comb begin
        n_key = i_symbol_in;
        if (r_dir && ({1'b0, i_symbol_in} >= NSZ)) begin
            n_key = NLST[SW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtfbc_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (!r_dir && ({1'b0, i_symbol_in} >= NSZ)) begin
                        n_state = mtfbc_pkg::S_FIN;
                    end else begin
                        n_state = mtfbc_pkg::S_RUN;
                    end
                end
            end
            mtfbc_pkg::S_RUN: begin
                if (w_hit_any) begin
                    n_state = mtfbc_pkg::S_FIN;
                end
            end
            mtfbc_pkg::S_FIN: begin
                if (w_finish) begin
                    n_state = mtfbc_pkg::S_IDLE;
                end
            end
            default: n_state = mtfbc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mtfbc_pkg::S_IDLE;
            r_dir       <= 1'b0;
            r_launch    <= 1'b0;
            r_out_valid <= 1'b0;
            r_wr        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= 1'b0;
            if (i_cfg_valid) begin
                r_dir <= i_cfg_data;
            end
            if (w_accept) begin
                r_launch <= (n_state == mtfbc_pkg::S_RUN);
                r_wr     <= (n_state == mtfbc_pkg::S_RUN);
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key  <= n_key;
            r_idx  <= '0;
            r_rank <= NSZ[SW-1:0];
        end else if (r_state == mtfbc_pkg::S_RUN) begin
            r_idx <= r_idx + 1'b1;
            if (w_hit_any) begin
                r_found <= w_hit_val;
                r_rank  <= r_idx;
            end
        end
        if (w_finish) begin
            r_out <= r_dir ? r_found : r_rank;
        end
    end

endmodule
